// ===== rtl/vfcm_pkg.sv =====
// Shared types, constants and lookup functions of the voxel face culling mesher.
`default_nettype none
package vfcm_pkg;

    localparam int CHUNK_DIM     = 32;
    localparam int TILES_PER_ROW = 4;

    localparam int COORD_W     = 5;
    localparam int LAYER_CELLS = CHUNK_DIM * CHUNK_DIM;
    localparam int VOX_AW      = $clog2(CHUNK_DIM * CHUNK_DIM * CHUNK_DIM);
    localparam int LAY_AW      = $clog2(6 * LAYER_CELLS);
    localparam int TILE_AW     = $clog2(256 * 6);

    localparam logic [2:0] OP_LOAD  = 3'd0;
    localparam logic [2:0] OP_EDIT  = 3'd1;
    localparam logic [2:0] OP_LAYER = 3'd2;
    localparam logic [2:0] OP_TILE  = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    // face / layer direction codes
    localparam logic [2:0] DIR_XN   = 3'd0;
    localparam logic [2:0] DIR_XP   = 3'd1;
    localparam logic [2:0] DIR_YP   = 3'd2;
    localparam logic [2:0] DIR_YN   = 3'd3;
    localparam logic [2:0] DIR_ZN   = 3'd4;
    localparam logic [2:0] DIR_ZP   = 3'd5;
    localparam logic [2:0] DIR_LAST = 3'd5;

    // dirty neighbour codes
    localparam logic [2:0] DIRTY_XN = 3'd0;
    localparam logic [2:0] DIRTY_XP = 3'd1;
    localparam logic [2:0] DIRTY_YN = 3'd2;
    localparam logic [2:0] DIRTY_YP = 3'd3;
    localparam logic [2:0] DIRTY_ZN = 3'd4;
    localparam logic [2:0] DIRTY_ZP = 3'd5;
    localparam logic [2:0] NO_DIRTY = 3'd6;

    localparam logic [7:0] VOX_AIR    = 8'd0;
    localparam logic [7:0] VOX_OPAQUE = 8'd4;
    localparam logic [7:0] VOX_CLEAR  = 8'd6;

    localparam logic [1:0] SHADE_X = 2'd0;
    localparam logic [1:0] SHADE_Z = 2'd1;
    localparam logic [1:0] SHADE_Y = 2'd2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_z;
        logic [2:0]         direction;
        logic [7:0]         block_id;
        logic [7:0]         tile_index;
    } vfcm_in_t;

    typedef struct packed {
        logic               is_face;
        logic [COORD_W-1:0] face_x;
        logic [COORD_W-1:0] face_y;
        logic [COORD_W-1:0] face_z;
        logic [2:0]         face_dir;
        logic [7:0]         face_block;
        logic [1:0]         tile_col;
        logic [5:0]         tile_row;
        logic [1:0]         brightness;
        logic               edit_accepted;
        logic [2:0]         dirty_neighbour;
        logic               last;
    } vfcm_out_t;

    // store port requests
    typedef struct packed {
        logic              vox_we;
        logic              vox_re;
        logic [VOX_AW-1:0] vox_addr;
        logic [7:0]        vox_wdata;
        logic              lay_we;
        logic              lay_re;
        logic [LAY_AW-1:0] lay_addr;
        logic [7:0]        lay_wdata;
        logic              tile_we;
        logic              tile_re;
        logic [TILE_AW-1:0] tile_addr;
        logic [7:0]        tile_wdata;
    } store_req_t;

    // address unit results
    typedef struct packed {
        logic              nb_inside;
        logic [VOX_AW-1:0] vox_addr;
        logic              lay_ok;
        logic [LAY_AW-1:0] lay_addr;
        logic [2:0]        pbit;
    } addr_info_t;

    typedef logic [255:0][7:0] lut8_t;

    function automatic lut8_t build_row_lut();
        lut8_t lut;
        for (int i = 0; i < 256; i++) begin
            lut[i] = 8'(i / TILES_PER_ROW);
        end
        return lut;
    endfunction

    function automatic lut8_t build_col_lut();
        lut8_t lut;
        for (int i = 0; i < 256; i++) begin
            lut[i] = 8'(i % TILES_PER_ROW);
        end
        return lut;
    endfunction

    localparam lut8_t TILE_ROW_LUT = build_row_lut();
    localparam lut8_t TILE_COL_LUT = build_col_lut();

    // scan position -> face direction
    function automatic logic [2:0] scan_dir(input logic [2:0] idx);
        logic [2:0] d;
        case (idx)
            3'd0:    d = DIR_XN;
            3'd1:    d = DIR_XP;
            3'd2:    d = DIR_ZN;
            3'd3:    d = DIR_ZP;
            3'd4:    d = DIR_YN;
            default: d = DIR_YP;
        endcase
        return d;
    endfunction

    // direction -> bit of neighbour_present
    function automatic logic [2:0] present_bit(input logic [2:0] d);
        logic [2:0] b;
        case (d)
            DIR_YP:  b = 3'd3;
            DIR_YN:  b = 3'd2;
            default: b = d;
        endcase
        return b;
    endfunction

    function automatic logic [1:0] shade_of(input logic [2:0] d);
        logic [1:0] s;
        case (d)
            DIR_XN, DIR_XP: s = SHADE_X;
            DIR_YP, DIR_YN: s = SHADE_Y;
            default:        s = SHADE_Z;
        endcase
        return s;
    endfunction

    function automatic logic [TILE_AW-1:0] tile_addr(input logic [7:0] blk,
                                                     input logic [2:0] d);
        return (TILE_AW'(blk) << 2) + (TILE_AW'(blk) << 1) + TILE_AW'(d);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/vfcm_store.sv =====
// Voxel store, neighbour boundary layers and tile table, one port each.
`default_nettype none
module vfcm_store (
    input  wire logic                aclk,
    input  wire vfcm_pkg::store_req_t req,
    output logic [7:0]               vox_rdata,
    output logic [7:0]               lay_rdata,
    output logic [7:0]               tile_rdata
);
    import vfcm_pkg::*;

    logic [7:0] vox_mem  [CHUNK_DIM*CHUNK_DIM*CHUNK_DIM];
    logic [7:0] lay_mem  [6*LAYER_CELLS];
    logic [7:0] tile_mem [256*6];

    always_ff @(posedge aclk) begin
        if (req.vox_we) begin
            vox_mem[req.vox_addr] <= req.vox_wdata;
        end
        if (req.vox_re) begin
            vox_rdata <= vox_mem[req.vox_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.lay_we) begin
            lay_mem[req.lay_addr] <= req.lay_wdata;
        end
        if (req.lay_re) begin
            lay_rdata <= lay_mem[req.lay_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.tile_we) begin
            tile_mem[req.tile_addr] <= req.tile_wdata;
        end
        if (req.tile_re) begin
            tile_rdata <= tile_mem[req.tile_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/vfcm_addr_unit.sv =====
// Shared address unit: neighbour coordinate, bounds check, voxel and layer addresses.
`default_nettype none
module vfcm_addr_unit (
    input  wire logic [vfcm_pkg::COORD_W-1:0] x,
    input  wire logic [vfcm_pkg::COORD_W-1:0] y,
    input  wire logic [vfcm_pkg::COORD_W-1:0] z,
    input  wire logic [2:0]                   dir,
    input  wire logic                         step_en,
    output vfcm_pkg::addr_info_t              info
);
    import vfcm_pkg::*;

    localparam int CW = COORD_W + 1;

    logic [CW-1:0] ex, ey, ez, nx, ny, nz, la, lb;

    assign ex = {1'b0, x};
    assign ey = {1'b0, y};
    assign ez = {1'b0, z};

    // underflow wraps to all ones, which lands beyond the chunk
    always_comb begin
        nx = ex;
        ny = ey;
        nz = ez;
        if (step_en) begin
            case (dir)
                DIR_XN:  nx = ex - CW'(1);
                DIR_XP:  nx = ex + CW'(1);
                DIR_YP:  ny = ey + CW'(1);
                DIR_YN:  ny = ey - CW'(1);
                DIR_ZN:  nz = ez - CW'(1);
                DIR_ZP:  nz = ez + CW'(1);
                default: nx = ex;
            endcase
        end
    end

    // layer cell coordinates perpendicular to dir
    always_comb begin
        case (dir)
            DIR_XN, DIR_XP: begin la = ey; lb = ez; end
            DIR_YP, DIR_YN: begin la = ex; lb = ez; end
            default:        begin la = ex; lb = ey; end
        endcase
    end

    always_comb begin
        info.nb_inside = (nx < CW'(CHUNK_DIM)) && (ny < CW'(CHUNK_DIM)) &&
                         (nz < CW'(CHUNK_DIM));
        info.vox_addr  = VOX_AW'(nx) + VOX_AW'(ny) * VOX_AW'(CHUNK_DIM) +
                         VOX_AW'(nz) * VOX_AW'(CHUNK_DIM * CHUNK_DIM);
        info.lay_ok    = (la < CW'(CHUNK_DIM)) && (lb < CW'(CHUNK_DIM));
        info.lay_addr  = LAY_AW'(dir) * LAY_AW'(LAYER_CELLS) +
                         LAY_AW'(la) * LAY_AW'(CHUNK_DIM) + LAY_AW'(lb);
        info.pbit      = present_bit(dir);
    end

endmodule
`default_nettype wire

// ===== rtl/voxel_face_culling_mesher.sv =====
// Top level of the voxel face culling mesher: sequencer, output register, config.
//
// One transaction at a time. A load, layer or tile write goes from dispatch
// back to idle; an edit reads the center voxel, updates it and waits in emit
// through any output stall; a query reads the center voxel and its six neighbours
// one after another, then for each visible face reads the tile, formats it and
// hands it to the output register. A query on air ends after the center read.
// The reads are serial: one address unit drives the single read port of the
// voxel store for the center and each neighbour in turn. Results sit in an
// output register; a stalled m_ready holds the next result in emit. The stores
// are not cleared at reset; reading an entry never written gives an undefined
// value. The user must write neighbour_present through cfg_wr_en and cfg_wr_data
// only while the block is idle; this is not enforced. It resets to zero.
`default_nettype none
module voxel_face_culling_mesher (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [5:0]          cfg_wr_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire vfcm_pkg::vfcm_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output vfcm_pkg::vfcm_out_t      m_data
);
    import vfcm_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_EDIT_RD  = 8'b0000_0100,
        S_QRY_CTR  = 8'b0000_1000,
        S_QRY_NB   = 8'b0001_0000,
        S_TILE_RD  = 8'b0010_0000,
        S_TILE_OUT = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    vfcm_in_t    item_reg;
    logic [5:0]  present_reg;
    logic [7:0]  blk_reg, blk_next;
    logic [2:0]  idx_reg, idx_next;     // scan position of the neighbour read
    logic [5:0]  mask_reg, mask_next;   // visible faces, by scan position
    logic [2:0]  sel_reg, sel_next;     // scan position being emitted
    logic        src_in_reg, src_in_next;   // neighbour came from voxel store
    logic        src_pr_reg, src_pr_next;   // neighbour chunk present
    vfcm_out_t   pend_reg, pend_next;
    logic        m_valid_reg;
    vfcm_out_t   m_data_reg;

    store_req_t  req;
    logic [7:0]  vox_rdata, lay_rdata, tile_rdata;
    addr_info_t  info;
    logic        au_step;
    logic [2:0]  au_dir, issue_idx;
    logic        out_free;
    logic [7:0]  nb_val;
    logic        nb_vis;
    logic [2:0]  first_idx;
    logic [5:0]  mask_left;
    logic [2:0]  sel_dir;

    vfcm_store u_store (
        .aclk       (aclk),
        .req        (req),
        .vox_rdata  (vox_rdata),
        .lay_rdata  (lay_rdata),
        .tile_rdata (tile_rdata)
    );

    vfcm_addr_unit u_addr (
        .x       (item_reg.pos_x),
        .y       (item_reg.pos_y),
        .z       (item_reg.pos_z),
        .dir     (au_dir),
        .step_en (au_step),
        .info    (info)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // neighbour reads step away from the center; everything else uses it
    assign issue_idx = (state_reg == S_QRY_CTR) ? 3'd0 : idx_reg + 3'd1;
    assign au_step   = (state_reg == S_QRY_CTR) || (state_reg == S_QRY_NB);
    assign au_dir    = au_step ? scan_dir(issue_idx) : item_reg.direction;

    // neighbour value: voxel store, boundary layer, or opaque when missing
    always_comb begin
        if (src_in_reg) begin
            nb_val = vox_rdata;
        end else if (src_pr_reg) begin
            nb_val = lay_rdata;
        end else begin
            nb_val = VOX_OPAQUE;
        end
    end
    assign nb_vis = (nb_val == VOX_AIR) || (nb_val == VOX_CLEAR);

    always_comb begin
        first_idx = 3'd0;
        for (int i = 5; i >= 0; i--) begin
            if (mask_reg[i]) begin
                first_idx = 3'(i);
            end
        end
    end

    assign sel_dir = scan_dir(sel_reg);

    always_comb begin
        mask_left          = mask_reg;
        mask_left[sel_reg] = 1'b0;
    end

    function automatic logic [2:0] pick_dirty(input vfcm_in_t it, input logic [5:0] p);
        logic [2:0] d;
        if (it.pos_x == '0 && p[0]) begin
            d = DIRTY_XN;
        end else if (it.pos_x == COORD_W'(CHUNK_DIM - 1) && p[1]) begin
            d = DIRTY_XP;
        end else if (it.pos_y == '0 && p[2]) begin
            d = DIRTY_YN;
        end else if (it.pos_y == COORD_W'(CHUNK_DIM - 1) && p[3]) begin
            d = DIRTY_YP;
        end else if (it.pos_z == '0 && p[4]) begin
            d = DIRTY_ZN;
        end else if (it.pos_z == COORD_W'(CHUNK_DIM - 1) && p[5]) begin
            d = DIRTY_ZP;
        end else begin
            d = NO_DIRTY;
        end
        return d;
    endfunction

    always_comb begin
        state_next  = state_reg;
        blk_next    = blk_reg;
        idx_next    = idx_reg;
        mask_next   = mask_reg;
        sel_next    = sel_reg;
        src_in_next = src_in_reg;
        src_pr_next = src_pr_reg;
        pend_next   = pend_reg;

        req            = '0;
        req.vox_addr   = info.vox_addr;
        req.vox_wdata  = item_reg.block_id;
        req.lay_addr   = info.lay_addr;
        req.lay_wdata  = item_reg.block_id;
        req.tile_addr  = tile_addr(item_reg.block_id, item_reg.direction);
        req.tile_wdata = item_reg.tile_index;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                state_next = S_IDLE;
                unique case (item_reg.opcode)
                    OP_LOAD: begin
                        req.vox_we = info.nb_inside;
                    end
                    OP_EDIT: begin
                        req.vox_re = info.nb_inside;
                        if (info.nb_inside) begin
                            state_next = S_EDIT_RD;
                        end
                    end
                    OP_LAYER: begin
                        req.lay_we = (item_reg.direction <= DIR_LAST) && info.lay_ok;
                    end
                    OP_TILE: begin
                        req.tile_we = (item_reg.direction <= DIR_LAST);
                    end
                    OP_QUERY: begin
                        req.vox_re = info.nb_inside;
                        if (info.nb_inside) begin
                            state_next = S_QRY_CTR;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_EDIT_RD: begin
                pend_next = '0;
                pend_next.dirty_neighbour = NO_DIRTY;
                pend_next.last = 1'b1;
                if (vox_rdata != VOX_OPAQUE && vox_rdata != item_reg.block_id) begin
                    req.vox_we                = 1'b1;
                    pend_next.edit_accepted   = 1'b1;
                    pend_next.dirty_neighbour = pick_dirty(item_reg, present_reg);
                end
                state_next = S_EMIT;
            end
            S_QRY_CTR: begin
                if (vox_rdata == VOX_AIR) begin
                    state_next = S_IDLE;
                end else begin
                    blk_next    = vox_rdata;
                    idx_next    = 3'd0;
                    mask_next   = '0;
                    src_in_next = info.nb_inside;
                    src_pr_next = present_reg[info.pbit];
                    req.vox_re  = info.nb_inside;
                    req.lay_re  = !info.nb_inside && present_reg[info.pbit];
                    state_next  = S_QRY_NB;
                end
            end
            S_QRY_NB: begin
                mask_next[idx_reg] = nb_vis;
                if (idx_reg == 3'd5) begin
                    if (mask_next != '0) begin
                        state_next = S_TILE_RD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    idx_next    = issue_idx;
                    src_in_next = info.nb_inside;
                    src_pr_next = present_reg[info.pbit];
                    req.vox_re  = info.nb_inside;
                    req.lay_re  = !info.nb_inside && present_reg[info.pbit];
                end
            end
            S_TILE_RD: begin
                sel_next      = first_idx;
                req.tile_re   = 1'b1;
                req.tile_addr = tile_addr(blk_reg, scan_dir(first_idx));
                state_next    = S_TILE_OUT;
            end
            S_TILE_OUT: begin
                pend_next.is_face         = 1'b1;
                pend_next.face_x          = item_reg.pos_x;
                pend_next.face_y          = item_reg.pos_y;
                pend_next.face_z          = item_reg.pos_z;
                pend_next.face_dir        = sel_dir;
                pend_next.face_block      = blk_reg;
                pend_next.tile_col        = TILE_COL_LUT[tile_rdata][1:0];
                pend_next.tile_row        = TILE_ROW_LUT[tile_rdata][5:0];
                pend_next.brightness      = shade_of(sel_dir);
                pend_next.edit_accepted   = 1'b0;
                pend_next.dirty_neighbour = NO_DIRTY;
                pend_next.last            = (mask_left == '0);
                mask_next                 = mask_left;
                state_next                = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    if (pend_reg.is_face && mask_reg != '0) begin
                        state_next = S_TILE_RD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            present_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                present_reg <= cfg_wr_data;
            end
            if (state_reg == S_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (state_reg == S_EMIT && out_free) begin
            m_data_reg <= pend_reg;
        end
        blk_reg    <= blk_next;
        idx_reg    <= idx_next;
        mask_reg   <= mask_next;
        sel_reg    <= sel_next;
        src_in_reg <= src_in_next;
        src_pr_reg <= src_pr_next;
        pend_reg   <= pend_next;
    end

endmodule
`default_nettype wire

// ===== tb/sv/tb_voxel_face_culling_mesher.sv =====
// Self-checking testbench for the voxel face culling mesher: random transactions, checked faces.
`timescale 1ns / 1ps
`default_nettype none
module tb_voxel_face_culling_mesher;
    import vfcm_pkg::*;

    localparam int RAND_ITEMS = 230;
    localparam int PHASES     = 5;
    localparam int HOLD_LEN   = 400;
    localparam int SETTLE     = 40;
    localparam int CYCLE_CAP  = 1500000;
    localparam int MAX_SHOWN  = 10;

    // faces are scanned in this order
    localparam logic [2:0] FACE_ORDER [6] = '{DIR_XN, DIR_XP, DIR_ZN, DIR_ZP, DIR_YN, DIR_YP};

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [5:0] cfg_wr_data = '0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    vfcm_in_t   s_data      = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    vfcm_out_t  m_data;

    voxel_face_culling_mesher u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always #5 aclk = ~aclk;

    // ---------------------------------------------------------------
    // Shadow of the block: stores, register, and expected face/edit queue
    // ---------------------------------------------------------------
    logic [7:0] vox_mem  [32768];
    logic [7:0] lay_mem  [6144];
    logic [7:0] tile_mem [1536];
    logic [5:0] present_mask = '0;
    vfcm_out_t  face_q [$];

    // what the stimulus side has already written; no undefined entry is ever read
    bit vox_def  [32768];
    bit lay_def  [6144];
    bit tile_def [1536];

    vfcm_in_t pend_q [$];
    int  mismatches = 0;
    int  cycles     = 0;
    int  send_gap   = 0;
    int  stall_left = 0;
    int  hold_left  = 0;
    bit  hold_req   = 0;
    bit  calm       = 0;

    function automatic int vox_at(logic [4:0] x, logic [4:0] y, logic [4:0] z);
        return {z, y, x};
    endfunction

    // boundary layer cell: the two coordinates across the direction pick it
    function automatic int layer_at(logic [2:0] d, logic [4:0] x, logic [4:0] y, logic [4:0] z);
        logic [4:0] a, b;
        if (d == DIR_XN || d == DIR_XP) begin
            a = y; b = z;
        end else if (d == DIR_YP || d == DIR_YN) begin
            a = x; b = z;
        end else begin
            a = x; b = y;
        end
        return d * LAYER_CELLS + a * CHUNK_DIM + b;
    endfunction

    // direction code -> register bit (y codes are swapped in the register)
    function automatic int mask_bit(logic [2:0] d);
        if (d == DIR_YP) return 3;
        if (d == DIR_YN) return 2;
        return d;
    endfunction

    function automatic logic [1:0] shade(logic [2:0] d);
        if (d == DIR_XN || d == DIR_XP) return SHADE_X;
        if (d == DIR_YP || d == DIR_YN) return SHADE_Y;
        return SHADE_Z;
    endfunction

    // returns 1 with the in-chunk neighbour coordinates, 0 if across the edge
    function automatic bit step_in(logic [2:0] d, logic [4:0] x, logic [4:0] y, logic [4:0] z,
                                   output logic [4:0] nx, output logic [4:0] ny,
                                   output logic [4:0] nz);
        int ix, iy, iz;
        ix = x; iy = y; iz = z;
        case (d)
            DIR_XN:  ix--;
            DIR_XP:  ix++;
            DIR_YP:  iy++;
            DIR_YN:  iy--;
            DIR_ZN:  iz--;
            default: iz++;
        endcase
        nx = ix[4:0]; ny = iy[4:0]; nz = iz[4:0];
        return ix >= 0 && ix < CHUNK_DIM && iy >= 0 && iy < CHUNK_DIM &&
               iz >= 0 && iz < CHUNK_DIM;
    endfunction

    function automatic logic [7:0] voxel_beyond(logic [2:0] d, logic [4:0] x, logic [4:0] y,
                                                logic [4:0] z);
        logic [4:0] nx, ny, nz;
        if (step_in(d, x, y, z, nx, ny, nz)) return vox_mem[vox_at(nx, ny, nz)];
        if (!present_mask[mask_bit(d)]) return VOX_OPAQUE;
        return lay_mem[layer_at(d, x, y, z)];
    endfunction

    function automatic logic [2:0] remesh_target(logic [4:0] x, logic [4:0] y, logic [4:0] z);
        if (x == 0 && present_mask[0]) return DIRTY_XN;
        if (x == CHUNK_DIM - 1 && present_mask[1]) return DIRTY_XP;
        if (y == 0 && present_mask[2]) return DIRTY_YN;
        if (y == CHUNK_DIM - 1 && present_mask[3]) return DIRTY_YP;
        if (z == 0 && present_mask[4]) return DIRTY_ZN;
        if (z == CHUNK_DIM - 1 && present_mask[5]) return DIRTY_ZP;
        return NO_DIRTY;
    endfunction

    // apply one accepted transaction to the shadow and queue its results
    function automatic void apply_and_predict(vfcm_in_t it);
        vfcm_out_t  r;
        logic [7:0] owner, old, nb, tile;
        logic [2:0] fd;
        int         n;
        n = 0;
        case (it.opcode)
            OP_LOAD: vox_mem[vox_at(it.pos_x, it.pos_y, it.pos_z)] = it.block_id;
            OP_EDIT: begin
                old = vox_mem[vox_at(it.pos_x, it.pos_y, it.pos_z)];
                r = '0;
                r.dirty_neighbour = NO_DIRTY;
                r.last = 1'b1;
                if (old != VOX_OPAQUE && old != it.block_id) begin
                    vox_mem[vox_at(it.pos_x, it.pos_y, it.pos_z)] = it.block_id;
                    r.edit_accepted   = 1'b1;
                    r.dirty_neighbour = remesh_target(it.pos_x, it.pos_y, it.pos_z);
                end
                face_q.push_back(r);
            end
            OP_LAYER: if (it.direction <= DIR_LAST)
                lay_mem[layer_at(it.direction, it.pos_x, it.pos_y, it.pos_z)] = it.block_id;
            OP_TILE: if (it.direction <= DIR_LAST)
                tile_mem[it.block_id * 6 + it.direction] = it.tile_index;
            OP_QUERY: begin
                owner = vox_mem[vox_at(it.pos_x, it.pos_y, it.pos_z)];
                if (owner != VOX_AIR) begin
                    for (int i = 0; i < 6; i++) begin
                        fd = FACE_ORDER[i];
                        nb = voxel_beyond(fd, it.pos_x, it.pos_y, it.pos_z);
                        if (nb == VOX_AIR || nb == VOX_CLEAR) begin
                            tile = tile_mem[owner * 6 + fd];
                            r = '0;
                            r.is_face    = 1'b1;
                            r.face_x     = it.pos_x;
                            r.face_y     = it.pos_y;
                            r.face_z     = it.pos_z;
                            r.face_dir   = fd;
                            r.face_block = owner;
                            r.tile_col   = 2'(tile % TILES_PER_ROW);
                            r.tile_row   = 6'(tile / TILES_PER_ROW);
                            r.brightness = shade(fd);
                            r.dirty_neighbour = NO_DIRTY;
                            face_q.push_back(r);
                            n++;
                        end
                    end
                    if (n > 0) face_q[face_q.size() - 1].last = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers: every read the block will do hits a written entry
    // ---------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // coordinates biased to the chunk edges and the center, full range otherwise
    function automatic logic [4:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 5'd0;
            1: return 5'd31;
            2: return 5'd1;
            3: return 5'd30;
            4: return 5'($urandom_range(15, 16));
            default: return 5'($urandom_range(0, 31));
        endcase
    endfunction

    // mix of air, clear and opaque so faces both show and cull
    function automatic logic [7:0] pick_block();
        case ($urandom_range(0, 9))
            0, 1, 2: return VOX_AIR;
            3:       return VOX_OPAQUE;
            4, 5:    return VOX_CLEAR;
            6, 7:    return 8'($urandom_range(1, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic put(logic [2:0] op, logic [4:0] x, logic [4:0] y, logic [4:0] z,
                       logic [2:0] d, logic [7:0] b, logic [7:0] t);
        vfcm_in_t it;
        it = '{opcode: op, pos_x: x, pos_y: y, pos_z: z, direction: d, block_id: b,
               tile_index: t};
        pend_q.push_back(it);
    endtask

    task automatic put_tile(logic [7:0] b, logic [2:0] d, logic [7:0] t);
        put(OP_TILE, pick_coord(), pick_coord(), pick_coord(), d, b, t);
        if (d <= DIR_LAST) tile_def[b * 6 + d] = 1;
    endtask

    // a block type that can land in the store needs its whole tile row
    task automatic cover_tiles(logic [7:0] b);
        for (int d = 0; d < 6; d++)
            if (!tile_def[b * 6 + d]) put_tile(b, 3'(d), 8'($urandom_range(0, 255)));
    endtask

    task automatic put_load(logic [4:0] x, logic [4:0] y, logic [4:0] z, logic [7:0] b);
        cover_tiles(b);
        put(OP_LOAD, x, y, z, 3'($urandom_range(0, 7)), b, 8'($urandom_range(0, 255)));
        vox_def[vox_at(x, y, z)] = 1;
    endtask

    task automatic put_layer(logic [2:0] d, logic [4:0] x, logic [4:0] y, logic [4:0] z,
                             logic [7:0] b);
        put(OP_LAYER, x, y, z, d, b, 8'($urandom_range(0, 255)));
        if (d <= DIR_LAST) lay_def[layer_at(d, x, y, z)] = 1;
    endtask

    task automatic cover_voxel(logic [4:0] x, logic [4:0] y, logic [4:0] z);
        if (!vox_def[vox_at(x, y, z)]) put_load(x, y, z, pick_block());
    endtask

    task automatic put_query(logic [4:0] x, logic [4:0] y, logic [4:0] z);
        logic [4:0] nx, ny, nz;
        cover_voxel(x, y, z);
        for (int d = 0; d < 6; d++) begin
            if (step_in(3'(d), x, y, z, nx, ny, nz)) cover_voxel(nx, ny, nz);
            else if (!lay_def[layer_at(3'(d), x, y, z)])
                put_layer(3'(d), x, y, z, pick_block());
        end
        put(OP_QUERY, x, y, z, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
            8'($urandom_range(0, 255)));
    endtask

    task automatic put_edit(logic [4:0] x, logic [4:0] y, logic [4:0] z, logic [7:0] b);
        cover_voxel(x, y, z);
        cover_tiles(b);
        put(OP_EDIT, x, y, z, 3'($urandom_range(0, 7)), b, 8'($urandom_range(0, 255)));
    endtask

    // one random transaction, weighted toward queries and edits
    task automatic put_random();
        int r;
        logic [4:0] x, y, z;
        r = $urandom_range(0, 99);
        x = pick_coord(); y = pick_coord(); z = pick_coord();
        if (r < 35) put_query(x, y, z);
        else if (r < 60) put_edit(x, y, z, pick_block());
        else if (r < 78) put_load(x, y, z, pick_block());
        else if (r < 88) put_layer(3'($urandom_range(0, 5)), x, y, z, pick_block());
        else if (r < 93) put_tile(8'($urandom_range(0, 255)), 3'($urandom_range(0, 5)),
                                  8'($urandom_range(0, 255)));
        else if (r < 97) put(3'($urandom_range(5, 7)), x, y, z, 3'($urandom_range(0, 7)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        // bad direction: layer and tile writes are dropped
        else if (r < 99) put_layer(3'($urandom_range(6, 7)), x, y, z, pick_block());
        else put_tile(8'($urandom_range(0, 255)), 3'($urandom_range(6, 7)),
                      8'($urandom_range(0, 255)));
    endtask

    // block has drained: nothing queued, nothing offered, nothing outstanding
    task automatic wait_drained();
        @(negedge aclk);
        while (pend_q.size() != 0 || s_valid || face_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_mask(logic [5:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        present_mask = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Driver: offers queued transactions, updates the shadow on accept
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) apply_and_predict(s_data);
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pend_q.size() != 0) begin
                    s_data  <= pend_q.pop_front();
                    s_valid <= 1'b1;
                    send_gap = calm ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random back-pressure, checks each result against the oldest one due
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        vfcm_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (face_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected result %p", m_data);
                end else begin
                    want = face_q.pop_front();
                    if (m_data.is_face !== want.is_face || m_data.face_x !== want.face_x ||
                        m_data.face_y !== want.face_y || m_data.face_z !== want.face_z ||
                        m_data.face_dir !== want.face_dir ||
                        m_data.face_block !== want.face_block ||
                        m_data.tile_col !== want.tile_col ||
                        m_data.tile_row !== want.tile_row ||
                        m_data.brightness !== want.brightness ||
                        m_data.edit_accepted !== want.edit_accepted ||
                        m_data.dirty_neighbour !== want.dirty_neighbour ||
                        m_data.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("mismatch: expected %p got %p", want, m_data);
                    end
                end
            end
            if (hold_req) begin
                hold_left = HOLD_LEN;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall_left = calm ? 0 : pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        logic [5:0] masks [PHASES];
        masks = '{6'h00, 6'h15, 6'h2A, 6'($urandom_range(0, 63)), 6'h3F};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: every neighbour present
        write_mask(6'h3F);
        put_tile(8'd255, DIR_ZP, 8'd255);
        put_tile(8'd255, DIR_XN, 8'd0);
        put_load(5'd31, 5'd31, 5'd31, 8'd255);
        put_load(5'd0, 5'd0, 5'd0, VOX_OPAQUE);
        put_layer(DIR_XP, 5'd0, 5'd31, 5'd31, VOX_AIR);
        put_layer(DIR_YP, 5'd31, 5'd7, 5'd31, VOX_CLEAR);
        put_layer(DIR_ZP, 5'd31, 5'd31, 5'd3, VOX_OPAQUE);
        put_load(5'd30, 5'd31, 5'd31, VOX_CLEAR);
        put_query(5'd31, 5'd31, 5'd31);     // faces across the edge and inside
        put_query(5'd0, 5'd0, 5'd0);
        put_edit(5'd0, 5'd0, 5'd0, 8'd1);   // refused: opaque voxel
        put_edit(5'd31, 5'd31, 5'd31, 8'd255); // refused: same value
        put_edit(5'd31, 5'd31, 5'd31, VOX_AIR); // accepted, marks +x
        put_query(5'd31, 5'd31, 5'd31);     // air, no faces
        put_edit(5'd16, 5'd15, 5'd16, 8'd2);   // interior, no neighbour to mark
        put(3'd5, 5'd1, 5'd2, 5'd3, DIR_XN, 8'd9, 8'd9);
        put(3'd6, 5'd31, 5'd31, 5'd31, 3'd7, 8'd255, 8'd255);
        put(3'd7, 5'd0, 5'd0, 5'd0, DIR_ZP, 8'd0, 8'd0);
        put_layer(3'd7, 5'd0, 5'd0, 5'd0, 8'd77);
        put_tile(8'd1, 3'd6, 8'd200);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            write_mask(masks[p]);
            calm = (p == 1);
            // count every queued transaction, setup writes included
            while (pend_q.size() < RAND_ITEMS / PHASES) put_random();
            if (p == 2) begin
                // long receiver hold-off while the sender keeps offering
                @(negedge aclk);
                hold_req = 1;
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
